// ===== hw/rtl/sfcs_pkg.sv =====
// sfcs_pkg: shared constants, codes and structs for the fractional circular shift block
// no dependencies; every other file of the block refers to it by scoped names
`timescale 1ns / 1ps

package sfcs_pkg;

  localparam int MAX_CHANNELS = 4096;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 8;
  localparam int SHIFT_BITS   = 25;
  localparam int COUNT_BITS   = 13;

  localparam int CH_BITS      = $clog2(MAX_CHANNELS);
  localparam int ADDR_BITS    = CH_BITS + 1;
  localparam int DEPTH        = 2 * MAX_CHANNELS;
  localparam int TOTAL_BITS   = COUNT_BITS + FRAC_BITS;
  localparam int WEIGHT_BITS  = FRAC_BITS + 1;
  localparam int SUM_BITS     = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int DIV_CNT_BITS = $clog2(SHIFT_BITS + 1);
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = SHIFT_BITS;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_AMOUNT    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS_IN_USE = CFG_IDX_BITS'(1);

  localparam logic [COUNT_BITS-1:0]  COUNT_MIN   = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX   = COUNT_BITS'(MAX_CHANNELS);
  localparam logic [WEIGHT_BITS-1:0] UNIT_WEIGHT = WEIGHT_BITS'(64'd1 << FRAC_BITS);

  localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
    SUM_BITS'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO =
    SUM_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SHIFT_GO,
    CS_SHIFT_RUN,
    CS_WHOLE_RUN
  } cfg_state_t;

  // shift settings from the configuration block to the buffer stage
  typedef struct packed {
    logic                  busy;
    logic [COUNT_BITS-1:0] n;
    logic [CH_BITS-1:0]    pend_k;
    logic [FRAC_BITS-1:0]  pend_r;
    logic [CH_BITS-1:0]    k_cur;
    logic [FRAC_BITS-1:0]  frac;
  } shift_ctl_t;

  // buffer stage to interpolation stage
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [FRAC_BITS-1:0]   weight;
    logic [SAMPLE_BITS-1:0] data_a;
    logic [SAMPLE_BITS-1:0] data_b;
  } stage_t;

endpackage

// ===== hw/rtl/sfcs_if.sv =====
// sfcs_if: channel interfaces of the fractional circular shift block
// depends on sfcs_pkg for field widths
`timescale 1ns / 1ps

interface sfcs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfcs_pkg::SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface sfcs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfcs_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                  frame_end;
  modport source (output valid, output sample_out, output frame_end, input ready);
  modport sink   (input valid, input sample_out, input frame_end, output ready);
endinterface

interface sfcs_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [sfcs_pkg::CFG_IDX_BITS-1:0]      index;
  logic [sfcs_pkg::CFG_DATA_BITS-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sfcs_rem_div.sv =====
// sfcs_rem_div: restoring remainder unit, one dividend bit per cycle
// depends on sfcs_pkg
`timescale 1ns / 1ps

module sfcs_rem_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sfcs_pkg::SHIFT_BITS-1:0] dividend,
  input  logic [sfcs_pkg::TOTAL_BITS-1:0] divisor,
  output logic                            done,
  output logic [sfcs_pkg::TOTAL_BITS-1:0] rem
);

  logic [sfcs_pkg::SHIFT_BITS-1:0]   dvd_r;
  logic [sfcs_pkg::TOTAL_BITS-1:0]   dvs_r;
  logic [sfcs_pkg::TOTAL_BITS-1:0]   rem_r;
  logic [sfcs_pkg::TOTAL_BITS-1:0]   rem_nxt;
  logic [sfcs_pkg::TOTAL_BITS:0]     trial;
  logic [sfcs_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                              busy_r;
  logic                              done_r;

  always_comb begin
    trial = {rem_r, dvd_r[sfcs_pkg::SHIFT_BITS-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = sfcs_pkg::TOTAL_BITS'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[sfcs_pkg::TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= sfcs_pkg::DIV_CNT_BITS'(sfcs_pkg::SHIFT_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - sfcs_pkg::DIV_CNT_BITS'(1);
        if (cnt_r == sfcs_pkg::DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/sfcs_cfg.sv =====
// sfcs_cfg: configuration registers and reduction of the shift to whole and fraction parts
// depends on sfcs_pkg, sfcs_if and sfcs_rem_div
`timescale 1ns / 1ps

module sfcs_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  sfcs_cfg_if.sink             cfg_chan,
  input  logic                 latch,
  output sfcs_pkg::shift_ctl_t ctl
);

  sfcs_pkg::cfg_state_t state_r;
  sfcs_pkg::cfg_state_t state_nxt;

  logic [sfcs_pkg::SHIFT_BITS-1:0] shift_r;
  logic [sfcs_pkg::COUNT_BITS-1:0] count_r;
  logic [sfcs_pkg::CH_BITS-1:0]    pend_k_r;
  logic [sfcs_pkg::FRAC_BITS-1:0]  pend_r_r;
  logic [sfcs_pkg::CH_BITS-1:0]    ws_r;
  logic [sfcs_pkg::FRAC_BITS-1:0]  fw_r;
  logic [sfcs_pkg::CH_BITS-1:0]    k_cur_r;

  logic                            cfg_acc;
  logic                            idx_ok;
  logic [sfcs_pkg::COUNT_BITS-1:0] n;
  logic [sfcs_pkg::TOTAL_BITS-1:0] total;
  logic [sfcs_pkg::SHIFT_BITS-1:0] shift_mag;
  logic [sfcs_pkg::TOTAL_BITS-1:0] rem_fix;

  logic                            div_start;
  logic [sfcs_pkg::SHIFT_BITS-1:0] div_dvd;
  logic [sfcs_pkg::TOTAL_BITS-1:0] div_dvs;
  logic                            div_done;
  logic [sfcs_pkg::TOTAL_BITS-1:0] div_rem;

  assign cfg_chan.ready = (state_r == sfcs_pkg::CS_IDLE);
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign idx_ok  = (cfg_chan.index == sfcs_pkg::REG_SHIFT_AMOUNT) ||
                   (cfg_chan.index == sfcs_pkg::REG_CHANNELS_IN_USE);

  // frame length with out of range counts clamped
  always_comb begin
    if (count_r < sfcs_pkg::COUNT_MIN) begin
      n = sfcs_pkg::COUNT_MIN;
    end else if (count_r > sfcs_pkg::COUNT_MAX) begin
      n = sfcs_pkg::COUNT_MAX;
    end else begin
      n = count_r;
    end
  end

  assign total     = {n, {sfcs_pkg::FRAC_BITS{1'b0}}};
  assign shift_mag = shift_r[sfcs_pkg::SHIFT_BITS-1] ? (~shift_r + 1'b1) : shift_r;
  // true modulo for negative shifts
  assign rem_fix   = (shift_r[sfcs_pkg::SHIFT_BITS-1] && (div_rem != '0)) ?
                     (total - div_rem) : div_rem;

  sfcs_rem_div u_rem_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dvd   = shift_mag;
    div_dvs   = total;
    case (state_r)
      sfcs_pkg::CS_IDLE: begin
        if (cfg_acc && idx_ok) begin
          state_nxt = sfcs_pkg::CS_SHIFT_GO;
        end
      end
      sfcs_pkg::CS_SHIFT_GO: begin
        div_start = 1'b1;
        state_nxt = sfcs_pkg::CS_SHIFT_RUN;
      end
      sfcs_pkg::CS_SHIFT_RUN: begin
        if (div_done) begin
          // latched whole shift reduced by the new frame length
          div_start = 1'b1;
          div_dvd   = sfcs_pkg::SHIFT_BITS'(ws_r);
          div_dvs   = sfcs_pkg::TOTAL_BITS'(n);
          state_nxt = sfcs_pkg::CS_WHOLE_RUN;
        end
      end
      sfcs_pkg::CS_WHOLE_RUN: begin
        if (div_done) begin
          state_nxt = sfcs_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = sfcs_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sfcs_pkg::CS_IDLE;
      shift_r  <= '0;
      count_r  <= sfcs_pkg::COUNT_MAX;
      pend_k_r <= '0;
      pend_r_r <= '0;
      ws_r     <= '0;
      fw_r     <= '0;
      k_cur_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc && (cfg_chan.index == sfcs_pkg::REG_SHIFT_AMOUNT)) begin
        shift_r <= cfg_chan.data[sfcs_pkg::SHIFT_BITS-1:0];
      end
      if (cfg_acc && (cfg_chan.index == sfcs_pkg::REG_CHANNELS_IN_USE)) begin
        count_r <= cfg_chan.data[sfcs_pkg::COUNT_BITS-1:0];
      end
      if ((state_r == sfcs_pkg::CS_SHIFT_RUN) && div_done) begin
        pend_k_r <= rem_fix[sfcs_pkg::FRAC_BITS +: sfcs_pkg::CH_BITS];
        pend_r_r <= rem_fix[sfcs_pkg::FRAC_BITS-1:0];
      end
      if ((state_r == sfcs_pkg::CS_WHOLE_RUN) && div_done) begin
        k_cur_r <= div_rem[sfcs_pkg::CH_BITS-1:0];
      end else if (latch) begin
        ws_r    <= pend_k_r;
        fw_r    <= pend_r_r;
        k_cur_r <= pend_k_r;
      end
    end
  end

  always_comb begin
    ctl.busy   = (state_r != sfcs_pkg::CS_IDLE);
    ctl.n      = n;
    ctl.pend_k = pend_k_r;
    ctl.pend_r = pend_r_r;
    ctl.k_cur  = k_cur_r;
    ctl.frac   = fw_r;
  end

endmodule

// ===== hw/rtl/sfcs_fbuf.sv =====
// sfcs_fbuf: ping-pong frame memory, channel addressing and the registered read stage
// depends on sfcs_pkg and sfcs_if
`timescale 1ns / 1ps

module sfcs_fbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  sfcs_in_if.sink              in_chan,
  input  sfcs_pkg::shift_ctl_t ctl,
  input  logic                 take,
  output logic                 latch,
  output sfcs_pkg::stage_t     stage
);

  logic [sfcs_pkg::SAMPLE_BITS-1:0] mem [sfcs_pkg::DEPTH];

  logic [sfcs_pkg::CH_BITS-1:0]     ci_r;
  logic                             bank_r;
  logic [sfcs_pkg::COUNT_BITS-1:0]  hw0_r;
  logic [sfcs_pkg::COUNT_BITS-1:0]  hw1_r;
  logic                             s1_valid_r;
  logic                             last_r;
  logic                             use_a_r;
  logic                             use_b_r;
  logic [sfcs_pkg::FRAC_BITS-1:0]   weight_r;
  logic [sfcs_pkg::SAMPLE_BITS-1:0] data_a_r;
  logic [sfcs_pkg::SAMPLE_BITS-1:0] data_b_r;

  logic                             accept;
  logic                             first;
  logic                             last;
  logic [sfcs_pkg::COUNT_BITS-1:0]  nm1;
  logic [sfcs_pkg::CH_BITS-1:0]     nm1_ch;
  logic [sfcs_pkg::CH_BITS-1:0]     m;
  logic [sfcs_pkg::CH_BITS-1:0]     k;
  logic [sfcs_pkg::FRAC_BITS-1:0]   w;
  logic [sfcs_pkg::COUNT_BITS:0]    t;
  logic [sfcs_pkg::COUNT_BITS:0]    a_wide;
  logic [sfcs_pkg::CH_BITS-1:0]     a;
  logic [sfcs_pkg::CH_BITS-1:0]     b;
  logic [sfcs_pkg::COUNT_BITS-1:0]  m_inc;
  logic [sfcs_pkg::COUNT_BITS-1:0]  hw_rd;
  logic [sfcs_pkg::COUNT_BITS-1:0]  hw_wr;

  assign in_chan.ready = !ctl.busy && (!s1_valid_r || take);
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    nm1    = ctl.n - sfcs_pkg::COUNT_BITS'(1);
    nm1_ch = nm1[sfcs_pkg::CH_BITS-1:0];
    // position clamped when the frame length was lowered mid-frame
    m      = (sfcs_pkg::COUNT_BITS'(ci_r) > nm1) ? nm1_ch : ci_r;
    first  = (ci_r == '0);
    k      = first ? ctl.pend_k : ctl.k_cur;
    w      = first ? ctl.pend_r : ctl.frac;
    t      = (sfcs_pkg::COUNT_BITS + 1)'(m) + (sfcs_pkg::COUNT_BITS + 1)'(ctl.n)
             - (sfcs_pkg::COUNT_BITS + 1)'(k);
    a_wide = (t >= (sfcs_pkg::COUNT_BITS + 1)'(ctl.n)) ?
             (t - (sfcs_pkg::COUNT_BITS + 1)'(ctl.n)) : t;
    a      = a_wide[sfcs_pkg::CH_BITS-1:0];
    b      = (a == '0) ? nm1_ch : (a - sfcs_pkg::CH_BITS'(1));
    last   = (sfcs_pkg::COUNT_BITS'(m) == nm1);
    m_inc  = sfcs_pkg::COUNT_BITS'(m) + sfcs_pkg::COUNT_BITS'(1);
    // read bank is the one not being written
    hw_rd  = bank_r ? hw0_r : hw1_r;
    hw_wr  = bank_r ? hw1_r : hw0_r;
  end

  assign latch = accept && first;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[{bank_r, m}] <= in_chan.sample_in;
      data_a_r         <= mem[{~bank_r, a}];
      data_b_r         <= mem[{~bank_r, b}];
      use_a_r          <= (sfcs_pkg::COUNT_BITS'(a) < hw_rd);
      use_b_r          <= (sfcs_pkg::COUNT_BITS'(b) < hw_rd);
      weight_r         <= w;
      last_r           <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r       <= '0;
      bank_r     <= 1'b0;
      hw0_r      <= '0;
      hw1_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          ci_r   <= '0;
          bank_r <= ~bank_r;
        end else begin
          ci_r <= m_inc[sfcs_pkg::CH_BITS-1:0];
        end
        // fill mark: entries below it have been written since reset
        if (m_inc > hw_wr) begin
          if (bank_r) begin
            hw1_r <= m_inc;
          end else begin
            hw0_r <= m_inc;
          end
        end
      end
    end
  end

  always_comb begin
    stage.valid  = s1_valid_r;
    stage.last   = last_r;
    stage.weight = weight_r;
    stage.data_a = use_a_r ? data_a_r : '0;
    stage.data_b = use_b_r ? data_b_r : '0;
  end

endmodule

// ===== hw/rtl/sfcs_interp.sv =====
// sfcs_interp: weighted sum of two neighbor samples, rounding and the result register
// depends on sfcs_pkg and sfcs_if
`timescale 1ns / 1ps

module sfcs_interp (
  input  logic             clk,
  input  logic             rst_n,
  input  sfcs_pkg::stage_t stage,
  output logic             take,
  sfcs_out_if.source       out_chan
);

  logic                                  out_valid_r;
  logic [sfcs_pkg::SAMPLE_BITS-1:0]      sample_out_r;
  logic                                  frame_end_r;

  logic [sfcs_pkg::WEIGHT_BITS-1:0]      wa;
  logic [sfcs_pkg::WEIGHT_BITS-1:0]      wb;
  logic signed [sfcs_pkg::SUM_BITS-1:0]  prod_a;
  logic signed [sfcs_pkg::SUM_BITS-1:0]  prod_b;
  logic signed [sfcs_pkg::SUM_BITS-1:0]  rounded;
  logic signed [sfcs_pkg::SUM_BITS-1:0]  q;
  logic signed [sfcs_pkg::SUM_BITS-1:0]  q_sat;

  assign take = !out_valid_r || out_chan.ready;

  always_comb begin
    wb      = sfcs_pkg::WEIGHT_BITS'(stage.weight);
    wa      = sfcs_pkg::UNIT_WEIGHT - wb;
    prod_a  = $signed({1'b0, wa}) * $signed(stage.data_a);
    prod_b  = $signed({1'b0, wb}) * $signed(stage.data_b);
    rounded = prod_a + prod_b + sfcs_pkg::ROUND_HALF;
    // arithmetic shift floors, so ties go toward plus infinity
    q       = rounded >>> sfcs_pkg::FRAC_BITS;
    if (q > sfcs_pkg::SAT_HI) begin
      q_sat = sfcs_pkg::SAT_HI;
    end else if (q < sfcs_pkg::SAT_LO) begin
      q_sat = sfcs_pkg::SAT_LO;
    end else begin
      q_sat = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage.valid) begin
      sample_out_r <= q_sat[sfcs_pkg::SAMPLE_BITS-1:0];
      frame_end_r  <= stage.last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = sample_out_r;
  assign out_chan.frame_end  = frame_end_r;

endmodule

// ===== hw/rtl/spectrum_fractional_circular_shift_top.sv =====
// spectrum_fractional_circular_shift_top: top level of the fractional circular shift block
// depends on sfcs_pkg, sfcs_if, sfcs_cfg, sfcs_fbuf and sfcs_interp
//
// usage
// - in_chan carries one spectrum sample per beat, channels in order, frames of
//   channels_in_use samples; every input beat yields exactly one out_chan beat
// - out_chan returns the previous frame circularly shifted by shift_amount/256
//   channels with linear interpolation; frame_end marks the last channel
// - the first frame after reset comes out as zeros (bank never written)
// - a beat passes the read stage, then the result register, before out_valid rises;
//   one beat per cycle while out_ready is high and no cfg write is pending
// - the rate is set by the two-read-port frame memory and one weighted sum
//   per beat, both fully pipelined
// - cfg_chan writes shift_amount (index 0) or channels_in_use (index 1); each
//   write starts the one shared remainder unit twice, so cfg_ready and
//   in_ready stay low until both reductions have finished
// - a new shift takes effect at the next frame start; a new frame length at once
// - reset (rst_n low, synchronous) clears control state and the per-bank fill
//   marks; there is no memory clearing pass, unwritten entries read as zero
// - when out_ready is low the result register holds and in_ready drops once
//   the read stage is also full; no beat is lost or repeated
`timescale 1ns / 1ps

module spectrum_fractional_circular_shift_top (
  input  logic       clk,
  input  logic       rst_n,
  sfcs_in_if.sink    in_chan,
  sfcs_out_if.source out_chan,
  sfcs_cfg_if.sink   cfg_chan
);

  // shift settings, latched per frame inside the config block
  sfcs_pkg::shift_ctl_t ctl;
  // read stage payload toward the interpolator
  sfcs_pkg::stage_t     stage;
  // frame start strobe back to the config block
  logic                 latch;
  // interpolator can load the read stage this cycle
  logic                 take;

  sfcs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .latch    (latch),
    .ctl      (ctl)
  );

  sfcs_fbuf u_fbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .ctl     (ctl),
    .take    (take),
    .latch   (latch),
    .stage   (stage)
  );

  sfcs_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule

// ===== hw/rtl/sfcs_checker.sv =====
// sfcs_checker: port level assertions for the fractional circular shift block
// depends on sfcs_pkg; bound to spectrum_fractional_circular_shift_top below
`timescale 1ns / 1ps

module sfcs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [sfcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [sfcs_pkg::SAMPLE_BITS-1:0]    sample_out,
  input logic                                frame_end
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(frame_end))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result comes from an accepted sample via the read stage and result register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted sample");

  // a register write holds off samples while the shift is reduced
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == sfcs_pkg::REG_SHIFT_AMOUNT || cfg_index == sfcs_pkg::REG_CHANNELS_IN_USE)
    |=> !in_ready && !cfg_ready)
    else $error("input open during shift reduction");

endmodule

bind spectrum_fractional_circular_shift_top sfcs_checker u_sfcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .cfg_valid  (cfg_chan.valid),
  .cfg_ready  (cfg_chan.ready),
  .cfg_index  (cfg_chan.index),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .sample_out (out_chan.sample_out),
  .frame_end  (out_chan.frame_end)
);
